// ===== hdl/bsc_pkg.sv =====
// Package: payload types, register indexes and constants for the pressure compensation block.
`default_nettype none
package bsc_pkg;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } req_payload_type;

   typedef struct packed {
      logic [31:0]        pressure_q24_8;
      logic signed [31:0] fine_temperature;
      logic               divide_by_zero;
   } rsp_payload_type;

   localparam logic [1:0] REG_TEMP    = 2'd0;
   localparam logic [1:0] REG_PRESS_A = 2'd1;
   localparam logic [1:0] REG_PRESS_B = 2'd2;
   localparam logic [1:0] REG_PRESS_C = 2'd3;

   localparam int          CSR_IDX_W   = 3;
   localparam int          CSR_DATA_W  = 48;
   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] P_OFFSET    = 64'd1048576;
   localparam logic [63:0] P_SCALE     = 64'd3125;
   localparam int          DIV_STEPS   = 64;

endpackage
`default_nettype wire

// ===== hdl/bsc_mul64.sv =====
// Module: pipelined 64x64 wrapping multiplier built from 32x32 partial products.
`default_nettype none
module bsc_mul64 (
   input  wire logic        clock,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic [63:0]      p
);
   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [63:0] ll_in;
   logic [31:0] lh_in;
   logic [31:0] hl_in;
   logic [63:0] ll2_ff;
   logic [31:0] cross_ff;
   logic [31:0] cross_in;
   logic [63:0] p_ff;
   logic [63:0] p_in;

   // Low-order products only: the upper half of the full product is dropped.
   // Stage 1 forms the partial products, stage 2 the cross sum, stage 3 the total.
   always_comb begin
      ll_in    = a[31:0] * b[31:0];
      lh_in    = 32'(a[31:0] * b[63:32]);
      hl_in    = 32'(a[63:32] * b[31:0]);
      cross_in = lh_ff + hl_ff;
      p_in     = ll2_ff + {cross_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      ll_ff    <= ll_in;
      lh_ff    <= lh_in;
      hl_ff    <= hl_in;
      ll2_ff   <= ll_ff;
      cross_ff <= cross_in;
      p_ff     <= p_in;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

// ===== hdl/bsc_div64.sv =====
// Module: pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
`default_nettype none
module bsc_div64 #(
   parameter int TAG_W = 8
) (
   input  wire logic             clock,
   input  wire logic [63:0]      num,
   input  wire logic [63:0]      den,
   input  wire logic [TAG_W-1:0] tag_in,
   output logic [63:0]           quo,
   output logic [TAG_W-1:0]      tag_out
);
   localparam int N = bsc_pkg::DIV_STEPS;

   logic [63:0]      rem_ff [N+1];
   logic [63:0]      q_ff   [N+1];
   logic [63:0]      d_ff   [N+1];
   logic             neg_ff [N+1];
   logic [TAG_W-1:0] tag_ff [N+1];
   logic [63:0]      q_out_ff;
   logic [TAG_W-1:0] tag_out_ff;

   always_ff @(posedge clock) begin
      rem_ff[0] <= 64'd0;
      q_ff[0]   <= num[63] ? 64'(-num) : num;
      d_ff[0]   <= den[63] ? 64'(-den) : den;
      neg_ff[0] <= num[63] ^ den[63];
      tag_ff[0] <= tag_in;
   end

   // One restoring step per stage; the partial remainder needs 65 bits.
   for (genvar i = 0; i < N; i++) begin : g_step
      logic [64:0] trial;
      logic [64:0] shifted;
      assign shifted = {rem_ff[i], q_ff[i][63]};
      assign trial   = shifted - {1'b0, d_ff[i]};
      always_ff @(posedge clock) begin
         if (!trial[64]) begin
            rem_ff[i+1] <= trial[63:0];
         end else begin
            rem_ff[i+1] <= shifted[63:0];
         end
         q_ff[i+1]   <= {q_ff[i][62:0], ~trial[64]};
         d_ff[i+1]   <= d_ff[i];
         neg_ff[i+1] <= neg_ff[i];
         tag_ff[i+1] <= tag_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      q_out_ff   <= neg_ff[N] ? 64'(-q_ff[N]) : q_ff[N];
      tag_out_ff <= tag_ff[N];
   end

   assign quo     = q_out_ff;
   assign tag_out = tag_out_ff;
endmodule
`default_nettype wire

// ===== hdl/baro_sensor_compensation_top.sv =====
// Top level: pipelined integer temperature and pressure compensation.
//
// Takes one request per clock (busy is always low) and returns one response per request,
// in order, after the temperature and pressure arithmetic, the 64-step restoring divider
// and the tail; the pressure path uses pipelined 64-bit multipliers. The response is shown
// for one cycle under rsp_valid and cannot be held off. fine_temperature is valid even
// when the pressure denominator is zero; then pressure is 0 and divide_by_zero is set.
// Write coefficients only while no request is in flight.
`default_nettype none
module baro_sensor_compensation_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire bsc_pkg::req_payload_type     req_payload,
   output logic                              rsp_valid,
   output bsc_pkg::rsp_payload_type          rsp_payload,
   input  wire logic                         csr_write,
   input  wire logic [bsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bsc_pkg::CSR_DATA_W-1:0] csr_data
);
   // Tag carried with each request through the divider: fine temp, dz flag.
   localparam int TAG_W = 32 + 1;
   localparam int MUL_LAT = 3;
   localparam int TAIL = 8;

   logic [47:0] temp_ff, pa_ff, pb_ff, pc_ff;

   // Hold the coefficient registers; drop writes beyond the last index.
   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff <= '0;
         pa_ff   <= '0;
         pb_ff   <= '0;
         pc_ff   <= '0;
      end else if (csr_write && csr_index[2] == 1'b0) begin
         unique case (csr_index[1:0])
            bsc_pkg::REG_TEMP:    temp_ff <= csr_data;
            bsc_pkg::REG_PRESS_A: pa_ff   <= csr_data;
            bsc_pkg::REG_PRESS_B: pb_ff   <= csr_data;
            bsc_pkg::REG_PRESS_C: pc_ff   <= csr_data;
            default:              temp_ff <= temp_ff;
         endcase
      end
   end

   function automatic logic [63:0] s16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {48'd0, temp_ff[15:0]};
   assign t2 = s16(temp_ff[31:16]);
   assign t3 = s16(temp_ff[47:32]);
   assign p1 = {48'd0, pa_ff[15:0]};
   assign p2 = s16(pa_ff[31:16]);
   assign p3 = s16(pa_ff[47:32]);
   assign p4 = s16(pb_ff[15:0]);
   assign p5 = s16(pb_ff[31:16]);
   assign p6 = s16(pb_ff[47:32]);
   assign p7 = s16(pc_ff[15:0]);
   assign p8 = s16(pc_ff[31:16]);
   assign p9 = s16(pc_ff[47:32]);

   assign busy = 1'b0;

   // Temperature stage 1: differences.
   logic        v1_ff;
   logic [31:0] a1_ff, d1_ff;
   logic [19:0] rp1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= start;
      a1_ff  <= 32'({12'd0, req_payload.raw_temperature} >> 3) - 32'({t1[30:0], 1'b0});
      d1_ff  <= 32'({12'd0, req_payload.raw_temperature} >> 4) - t1[31:0];
      rp1_ff <= req_payload.raw_pressure;
   end

   // Stage 2: a*T2 and d*d.
   logic        v2_ff;
   logic [31:0] at_ff, dd_ff;
   logic [19:0] rp2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      at_ff  <= a1_ff * t2[31:0];
      dd_ff  <= d1_ff * d1_ff;
      rp2_ff <= rp1_ff;
   end

   // Stage 3: scale a*T2 and form s*T3.
   logic        v3_ff;
   logic [31:0] tv1_ff, st_ff;
   logic [19:0] rp3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      tv1_ff <= 32'($signed(at_ff) >>> 11);
      st_ff  <= 32'($signed(32'($signed(dd_ff) >>> 12)) * $signed(t3[31:0]));
      rp3_ff <= rp2_ff;
   end

   // Stage 4: fine temperature and v1 = tfine - 128000.
   logic        v4_ff;
   logic [31:0] tf4_ff;
   logic [63:0] x4_ff;
   logic [19:0] rp4_ff;
   logic [31:0] tf4_in;
   assign tf4_in = tv1_ff + 32'($signed(st_ff) >>> 14);
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else       v4_ff <= v3_ff;
      tf4_ff <= tf4_in;
      x4_ff  <= {{32{tf4_in[31]}}, tf4_in} - bsc_pkg::FINE_OFFSET;
      rp4_ff <= rp3_ff;
   end

   // Stage group A: x*x, x*P5, x*P2.
   logic [63:0] xx, xp5, xp2;
   bsc_mul64 u_xx  (.clock(clock), .a(x4_ff), .b(x4_ff), .p(xx));
   bsc_mul64 u_xp5 (.clock(clock), .a(x4_ff), .b(p5),    .p(xp5));
   bsc_mul64 u_xp2 (.clock(clock), .a(x4_ff), .b(p2),    .p(xp2));

   logic        va_ff [MUL_LAT];
   logic [31:0] tfa_ff [MUL_LAT];
   logic [19:0] rpa_ff [MUL_LAT];
   always_ff @(posedge clock) begin
      if (reset) va_ff[0] <= 1'b0;
      else       va_ff[0] <= v4_ff;
      tfa_ff[0] <= tf4_ff;
      rpa_ff[0] <= rp4_ff;
      for (int i = 1; i < MUL_LAT; i++) begin
         if (reset) va_ff[i] <= 1'b0;
         else       va_ff[i] <= va_ff[i-1];
         tfa_ff[i] <= tfa_ff[i-1];
         rpa_ff[i] <= rpa_ff[i-1];
      end
   end

   // Group B: x*x*P6 and x*x*P3; carry the other terms alongside.
   logic [63:0] xxp6, xxp3;
   bsc_mul64 u_xxp6 (.clock(clock), .a(xx), .b(p6), .p(xxp6));
   bsc_mul64 u_xxp3 (.clock(clock), .a(xx), .b(p3), .p(xxp3));

   logic        vb_ff  [MUL_LAT];
   logic [31:0] tfb_ff [MUL_LAT];
   logic [19:0] rpb_ff [MUL_LAT];
   logic [63:0] xp5b_ff [MUL_LAT];
   logic [63:0] xp2b_ff [MUL_LAT];
   always_ff @(posedge clock) begin
      if (reset) vb_ff[0] <= 1'b0;
      else       vb_ff[0] <= va_ff[MUL_LAT-1];
      tfb_ff[0]  <= tfa_ff[MUL_LAT-1];
      rpb_ff[0]  <= rpa_ff[MUL_LAT-1];
      xp5b_ff[0] <= xp5;
      xp2b_ff[0] <= xp2;
      for (int i = 1; i < MUL_LAT; i++) begin
         if (reset) vb_ff[i] <= 1'b0;
         else       vb_ff[i] <= vb_ff[i-1];
         tfb_ff[i]  <= tfb_ff[i-1];
         rpb_ff[i]  <= rpb_ff[i-1];
         xp5b_ff[i] <= xp5b_ff[i-1];
         xp2b_ff[i] <= xp2b_ff[i-1];
      end
   end

   // Stage C: v2 sum, v1 before the P1 scaling, numerator base.
   logic        vc_ff;
   logic [31:0] tfc_ff;
   logic [63:0] v2c_ff, v1c_ff, pc64_ff;
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= vb_ff[MUL_LAT-1];
      tfc_ff  <= tfb_ff[MUL_LAT-1];
      v2c_ff  <= xxp6 + {xp5b_ff[MUL_LAT-1][46:0], 17'd0} + {p4[28:0], 35'd0};
      v1c_ff  <= (64'(1) << 47) + 64'($signed(xxp3) >>> 8)
                 + {xp2b_ff[MUL_LAT-1][51:0], 12'd0};
      pc64_ff <= bsc_pkg::P_OFFSET - {44'd0, rpb_ff[MUL_LAT-1]};
   end

   // Group D: v1*P1 and (p<<31 - v2)*3125.
   logic [63:0] v1p1, numer;
   bsc_mul64 u_v1p1 (.clock(clock), .a(v1c_ff), .b(p1), .p(v1p1));
   bsc_mul64 u_num  (.clock(clock), .a({pc64_ff[32:0], 31'd0} - v2c_ff),
                     .b(bsc_pkg::P_SCALE), .p(numer));

   logic        vd_ff  [MUL_LAT];
   logic [31:0] tfd_ff [MUL_LAT];
   always_ff @(posedge clock) begin
      if (reset) vd_ff[0] <= 1'b0;
      else       vd_ff[0] <= vc_ff;
      tfd_ff[0] <= tfc_ff;
      for (int i = 1; i < MUL_LAT; i++) begin
         if (reset) vd_ff[i] <= 1'b0;
         else       vd_ff[i] <= vd_ff[i-1];
         tfd_ff[i] <= tfd_ff[i-1];
      end
   end

   // Denominator; feed the divider. Zero denominator divides by one, result dropped.
   logic [63:0] den;
   logic        dz;
   assign den = 64'($signed(v1p1) >>> 33);
   assign dz  = (den == 64'd0);

   logic [TAG_W-1:0] tag_o;
   logic [63:0]      quo;
   bsc_div64 #(.TAG_W(TAG_W)) u_div (
      .clock(clock),
      .num(numer),
      .den(dz ? 64'd1 : den),
      .tag_in({tfd_ff[MUL_LAT-1], dz}),
      .quo(quo),
      .tag_out(tag_o)
   );

   // Carry the divider valid bits beside it; clear them on reset.
   logic [bsc_pkg::DIV_STEPS+1:0] dv_ff;
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else       dv_ff <= {dv_ff[bsc_pkg::DIV_STEPS:0], vd_ff[MUL_LAT-1]};
   end

   // Tail: p9*(p>>13)*(p>>13), p8*p, then final sum.
   logic [63:0] ph;
   assign ph = 64'($signed(quo) >>> 13);

   logic        ve_ff  [TAIL];
   logic [31:0] tfe_ff [TAIL];
   logic        dze_ff [TAIL];
   logic [63:0] pe_ff  [TAIL-2];
   logic [63:0] phe_ff [MUL_LAT];
   logic [63:0] v2e_ff [MUL_LAT];

   logic [63:0] q9, p8p;
   bsc_mul64 u_q9  (.clock(clock), .a(p9), .b(ph),  .p(q9));
   bsc_mul64 u_p8p (.clock(clock), .a(p8), .b(quo), .p(p8p));
   logic [63:0] q9h;
   bsc_mul64 u_q9h (.clock(clock), .a(q9), .b(phe_ff[MUL_LAT-1]), .p(q9h));

   // p8*p >> 19 is registered in v2e_ff; carry it to meet q9h.
   always_ff @(posedge clock) begin
      if (reset) ve_ff[0] <= 1'b0;
      else       ve_ff[0] <= dv_ff[bsc_pkg::DIV_STEPS+1];
      tfe_ff[0] <= tag_o[32:1];
      dze_ff[0] <= tag_o[0];
      for (int i = 1; i < TAIL; i++) begin
         if (reset) ve_ff[i] <= 1'b0;
         else       ve_ff[i] <= ve_ff[i-1];
         tfe_ff[i] <= tfe_ff[i-1];
         dze_ff[i] <= dze_ff[i-1];
      end
      pe_ff[0] <= quo;
      for (int i = 1; i < TAIL - 2; i++) begin
         pe_ff[i] <= pe_ff[i-1];
      end
      phe_ff[0] <= ph;
      v2e_ff[0] <= 64'($signed(p8p) >>> 19);
      for (int i = 1; i < MUL_LAT; i++) begin
         phe_ff[i] <= phe_ff[i-1];
         v2e_ff[i] <= v2e_ff[i-1];
      end
   end

   // Sum the terms into sum_ff, then shift and add P7 into press_ff.
   logic [63:0] sum_ff;
   logic [31:0] press_ff;
   always_ff @(posedge clock) begin
      sum_ff   <= pe_ff[TAIL-3] + 64'($signed(q9h) >>> 25) + v2e_ff[MUL_LAT-1];
      press_ff <= 32'($signed(sum_ff) >>> 8) + {p7[27:0], 4'd0};
   end

   assign rsp_valid                    = ve_ff[TAIL-1];
   assign rsp_payload.pressure_q24_8   = dze_ff[TAIL-1] ? 32'd0 : press_ff;
   assign rsp_payload.fine_temperature = tfe_ff[TAIL-1];
   assign rsp_payload.divide_by_zero   = dze_ff[TAIL-1];
endmodule
`default_nettype wire

// ===== hdl/bsc_checker.sv =====
// Checker: port-level properties of the compensation block, bound to the top level.
`default_nettype none
module bsc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     start,
   input wire logic                     busy,
   input wire logic                     rsp_valid,
   input wire bsc_pkg::rsp_payload_type rsp_payload
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.divide_by_zero |-> rsp_payload.pressure_q24_8 == 32'd0)
      else $error("pressure not zero on zero denominator");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response right after reset");
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##88 rsp_valid)
      else $error("response missing 88 cycles after request");
endmodule

bind baro_sensor_compensation_top bsc_checker u_bsc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
);
`default_nettype wire
